// ===== rtl/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared constants and codes for the polyline point projection block.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int IDX_W = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] OC_BEFORE = 2'd0;
  localparam logic [1:0] OC_PROJECTED = 2'd1;
  localparam logic [1:0] OC_SINGLE = 2'd2;
  localparam logic [1:0] OC_EMPTY = 2'd3;

  localparam logic REG_WAYPOINT_COUNT = 1'b0;

endpackage

// ===== rtl/ppp_req_if.sv =====
// ----------------------------------------------------------------------------
// ppp_req_if
// Request channel: waypoint store or query point.
// ----------------------------------------------------------------------------
interface ppp_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [5:0]         slot;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source (output valid, cmd, slot, x_coord, y_coord, input ready);
  modport sink (input valid, cmd, slot, x_coord, y_coord, output ready);
endinterface

// ===== rtl/ppp_res_if.sv =====
// ----------------------------------------------------------------------------
// ppp_res_if
// Result channel: mapped point, deciding segment and outcome.
// ----------------------------------------------------------------------------
interface ppp_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mapped_x;
  logic signed [31:0] mapped_y;
  logic [5:0]         segment;
  logic [1:0]         outcome;

  modport source (output valid, mapped_x, mapped_y, segment, outcome, input ready);
  modport sink (input valid, mapped_x, mapped_y, segment, outcome, output ready);
endinterface

// ===== rtl/ppp_ram.sv =====
// ----------------------------------------------------------------------------
// ppp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/polyline_point_projection_core.sv =====
// ----------------------------------------------------------------------------
// polyline_point_projection_core
// Projects a query point onto a stored polyline of waypoints.
//
// Requests arrive on req (valid/ready). A store request writes one waypoint
// into the table in the cycle it is accepted and gives no result. A query
// request walks the segments of the first waypoint_count waypoints and
// returns one result on res (valid/ready).
// waypoint_count is written over the APB port at address 0.
// A query of an empty table goes straight to the output register; a single
// waypoint is read and returned. Otherwise the first waypoint is read, then
// each segment walked is read and, unless of zero length, tested with four
// products, and the final projection uses one shift-add multiplier (33 steps)
// and one restoring divider (100 steps) once per coordinate before the output
// register is loaded. Store requests leave the sequencer idle.
// req.ready is low while a query is at work. The result sits in an output
// register; if res.ready stays low the next query finishes and waits until
// the register is free. Reset clears the sequencer, the output valid flag and
// waypoint_count; the waypoint table holds garbage until written.
// ----------------------------------------------------------------------------
module polyline_point_projection_core (
  input  logic        clk,
  input  logic        rst,
  ppp_req_if.sink     req,
  ppp_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0 = 4'd1;
  localparam logic [3:0] S_W0 = 4'd2;
  localparam logic [3:0] S_RDN = 4'd3;
  localparam logic [3:0] S_LOADN = 4'd4;
  localparam logic [3:0] S_M1 = 4'd5;
  localparam logic [3:0] S_M2 = 4'd6;
  localparam logic [3:0] S_M3 = 4'd7;
  localparam logic [3:0] S_M4 = 4'd8;
  localparam logic [3:0] S_M5 = 4'd9;
  localparam logic [3:0] S_DEC = 4'd10;
  localparam logic [3:0] S_MUL = 4'd11;
  localparam logic [3:0] S_DIV = 4'd12;
  localparam logic [3:0] S_ADD = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  localparam int IW = ppp_pkg::IDX_W;
  localparam int CW = ppp_pkg::CNT_W;

  logic [3:0]           state;
  logic [6:0]           count;
  logic [CW-1:0]        n;
  logic [IW-1:0]        i;
  logic signed [31:0]   px, py, x0, y0, nx, ny;
  logic signed [32:0]   dx, dy, vx, vy;
  logic signed [65:0]   mreg;
  logic signed [66:0]   t;
  logic [66:0]          dd;
  logic [32:0]          mag;
  logic [99:0]          acc;
  logic [67:0]          rem;
  logic [41:0]          q;
  logic                 ovf;
  logic                 comp;
  logic [6:0]           cnt;
  logic signed [31:0]   rx, ry;
  logic [5:0]           rseg;
  logic [1:0]           roc;

  logic                 ram_we;
  logic [IW-1:0]        ram_raddr;
  logic [63:0]          ram_rdata;
  logic [CW-1:0]        n_full;
  logic                 last;
  logic signed [31:0]   rd_x, rd_y;
  logic signed [32:0]   ldx, ldy;
  logic signed [32:0]   opa, opb;
  logic signed [65:0]   prod;
  logic [67:0]          rem_s;
  logic                 rem_ge;
  logic [40:0]          off;
  logic signed [31:0]   w_sel;
  logic                 c_neg;
  logic signed [42:0]   sum;
  logic signed [31:0]   sat;
  logic                 out_free;

  assign req.ready = (state == S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ppp_pkg::REG_WAYPOINT_COUNT) ? {25'd0, count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 7'd0;
    end else if (psel && penable && pwrite && paddr[2] == ppp_pkg::REG_WAYPOINT_COUNT) begin
      count <= pwdata[6:0];
    end
  end

  assign ram_we = req.valid && req.ready && req.cmd == ppp_pkg::CMD_STORE &&
                  CW'(req.slot) < CW'(ppp_pkg::MAX_WAYPOINTS) &&
                  (CW > 6 || req.slot < 6'(ppp_pkg::MAX_WAYPOINTS));
  assign ram_raddr = (state == S_RD0) ? '0 : i + IW'(1);

  ppp_ram #(
    .WIDTH(64),
    .DEPTH(ppp_pkg::MAX_WAYPOINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(req.slot)),
    .wdata ({req.y_coord, req.x_coord}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign n_full = CW'(count);
  assign last = (CW'(i) + CW'(2)) == n;
  assign rd_x = ram_rdata[31:0];
  assign rd_y = ram_rdata[63:32];
  assign ldx = 33'(rd_x) - 33'(x0);
  assign ldy = 33'(rd_y) - 33'(y0);

  always_comb begin
    case (state)
      S_M1: begin
        opa = dx;
        opb = vx;
      end
      S_M2: begin
        opa = dy;
        opb = vy;
      end
      S_M3: begin
        opa = dx;
        opb = dx;
      end
      default: begin
        opa = dy;
        opb = dy;
      end
    endcase
  end
  assign prod = opa * opb;

  assign rem_s = {rem[66:0], acc[99]};
  assign rem_ge = rem_s >= {1'b0, dd};

  assign off = (ovf || q > 42'h100_0000_0000) ? 41'h100_0000_0000 : q[40:0];
  assign w_sel = comp ? y0 : x0;
  assign c_neg = comp ? dy[32] : dx[32];
  assign sum = c_neg ? 43'(w_sel) - $signed({2'b00, off})
                     : 43'(w_sel) + $signed({2'b00, off});
  always_comb begin
    if (sum[42:31] == '0 || sum[42:31] == '1) begin
      sat = sum[31:0];
    end else if (sum[42]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7fff_ffff;
    end
  end

  assign out_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid && req.cmd == ppp_pkg::CMD_QUERY) begin
            px <= req.x_coord;
            py <= req.y_coord;
            n <= (n_full > CW'(ppp_pkg::MAX_WAYPOINTS)) ? CW'(ppp_pkg::MAX_WAYPOINTS) : n_full;
            if (n_full == '0) begin
              rx <= req.x_coord;
              ry <= req.y_coord;
              rseg <= 6'd0;
              roc <= ppp_pkg::OC_EMPTY;
              state <= S_DONE;
            end else begin
              state <= S_RD0;
            end
          end
        end
        S_RD0: state <= S_W0;
        S_W0: begin
          x0 <= rd_x;
          y0 <= rd_y;
          i <= '0;
          if (n == CW'(1)) begin
            rx <= rd_x;
            ry <= rd_y;
            rseg <= 6'd0;
            roc <= ppp_pkg::OC_SINGLE;
            state <= S_DONE;
          end else begin
            state <= S_RDN;
          end
        end
        S_RDN: state <= S_LOADN;
        S_LOADN: begin
          nx <= rd_x;
          ny <= rd_y;
          dx <= ldx;
          dy <= ldy;
          vx <= 33'(px) - 33'(x0);
          vy <= 33'(py) - 33'(y0);
          if (ldx == '0 && ldy == '0) begin
            if (last) begin
              rx <= x0;
              ry <= y0;
              rseg <= 6'(i);
              roc <= ppp_pkg::OC_PROJECTED;
              state <= S_DONE;
            end else begin
              x0 <= rd_x;
              y0 <= rd_y;
              i <= i + IW'(1);
              state <= S_RDN;
            end
          end else begin
            state <= S_M1;
          end
        end
        S_M1: begin
          mreg <= prod;
          state <= S_M2;
        end
        S_M2: begin
          t <= 67'(mreg);
          mreg <= prod;
          state <= S_M3;
        end
        S_M3: begin
          t <= t + 67'(mreg);
          mreg <= prod;
          state <= S_M4;
        end
        S_M4: begin
          dd <= {1'b0, mreg};
          mreg <= prod;
          state <= S_M5;
        end
        S_M5: begin
          dd <= dd + {1'b0, mreg};
          state <= S_DEC;
        end
        S_DEC: begin
          if (t[66]) begin
            rx <= x0;
            ry <= y0;
            rseg <= 6'(i);
            roc <= ppp_pkg::OC_BEFORE;
            state <= S_DONE;
          end else if ($unsigned(t) < dd || last) begin
            comp <= 1'b0;
            mag <= dx[32] ? 33'(-dx) : 33'(dx);
            acc <= '0;
            cnt <= '0;
            state <= S_MUL;
          end else begin
            x0 <= nx;
            y0 <= ny;
            i <= i + IW'(1);
            state <= S_RDN;
          end
        end
        S_MUL: begin
          acc <= {acc[98:0], 1'b0} + (mag[32] ? 100'($unsigned(t)) : 100'd0);
          mag <= {mag[31:0], 1'b0};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd32) begin
            cnt <= '0;
            rem <= '0;
            q <= '0;
            ovf <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          acc <= {acc[98:0], 1'b0};
          rem <= rem_ge ? rem_s - {1'b0, dd} : rem_s;
          q <= {q[40:0], rem_ge};
          ovf <= ovf | q[41];
          cnt <= cnt + 7'd1;
          if (cnt == 7'd99) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (!comp) begin
            rx <= sat;
            comp <= 1'b1;
            mag <= dy[32] ? 33'(-dy) : 33'(dy);
            acc <= '0;
            cnt <= '0;
            state <= S_MUL;
          end else begin
            ry <= sat;
            rseg <= 6'(i);
            roc <= ppp_pkg::OC_PROJECTED;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res.mapped_x <= rx;
            res.mapped_y <= ry;
            res.segment <= rseg;
            res.outcome <= roc;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_empty_seg: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.outcome == ppp_pkg::OC_EMPTY |-> res.segment == 6'd0)
    else $error("empty table result with nonzero segment");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> rem < {1'b0, dd})
    else $error("divider remainder not below divisor");

  a_dd_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> dd != '0)
    else $error("projection with zero-length segment");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.cmd == ppp_pkg::CMD_QUERY |=> !req.ready)
    else $error("ready held during query");

endmodule
